@@ rtl/adc_pkg.sv @@
`timescale 1ns / 1ps

package adc_pkg;

  localparam int LEVEL_FRAC_BITS_DEF = 16;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int COEF_BITS           = 16;

  localparam int TARGET_W     = 15;
  localparam int COEF_W       = 16;
  localparam int MIN_ENERGY_W = 18;
  localparam int CFG_DATA_W   = 18;
  localparam int CFG_INDEX_W  = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_LEVEL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PEAK_DECAY   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_ENERGY   = 3'd4;

  localparam logic [TARGET_W-1:0]     TARGET_RESET     = 15'd22937;
  localparam logic [COEF_W-1:0]       PEAK_DECAY_RESET = 16'd33;
  localparam logic [COEF_W-1:0]       ATTACK_RESET     = 16'd3277;
  localparam logic [COEF_W-1:0]       RELEASE_RESET    = 16'd33;
  localparam logic [MIN_ENERGY_W-1:0] MIN_ENERGY_RESET = 18'd13107;

  typedef struct packed {
    logic [TARGET_W-1:0]     target_level;
    logic [COEF_W-1:0]       peak_decay_coef;
    logic [COEF_W-1:0]       attack_coef;
    logic [COEF_W-1:0]       release_coef;
    logic [MIN_ENERGY_W-1:0] min_energy;
  } adc_cfg_t;

endpackage

@@ rtl/adc_front.sv @@
`timescale 1ns / 1ps

module adc_front #(
  parameter int SAMPLE_BITS = adc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          q_full,
  output logic                          q_push,
  output logic                          q_neg,
  output logic        [SAMPLE_BITS-1:0] q_mag
);

  logic [SAMPLE_BITS-1:0] raw;

  // The most negative sample has a magnitude that still fits as unsigned.
  assign raw      = sample_in;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_neg    = raw[SAMPLE_BITS-1];
  assign q_mag    = q_neg ? (~raw + 1'b1) : raw;

endmodule

@@ rtl/adc_fifo.sv @@
`timescale 1ns / 1ps

module adc_fifo #(
  parameter int WIDTH = adc_pkg::SAMPLE_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= push_data;
        wr_ptr      <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ rtl/adc_div.sv @@
`timescale 1ns / 1ps

module adc_div #(
  parameter int DW = adc_pkg::SAMPLE_BITS_DEF + adc_pkg::LEVEL_FRAC_BITS_DEF,
  parameter int VW = adc_pkg::LEVEL_FRAC_BITS_DEF + 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] dvs;
  logic [VW-1:0] rem;
  logic [DW-1:0] rq;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  // Restoring division, one quotient bit per cycle shifted in behind the dividend.
  assign trial    = {rem, rq[DW-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = (trial >= {1'b0, dvs});
  assign quotient = rq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
        dvs  <= divisor;
        rem  <= '0;
        rq   <= dividend;
      end else if (busy) begin
        rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
        rq  <= {rq[DW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/adc_back.sv @@
`timescale 1ns / 1ps

module adc_back #(
  parameter int LEVEL_FRAC_BITS = adc_pkg::LEVEL_FRAC_BITS_DEF,
  parameter int SAMPLE_BITS     = adc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  adc_pkg::adc_cfg_t             cfg,
  input  logic                          q_valid,
  input  logic                          q_neg,
  input  logic        [SAMPLE_BITS-1:0] q_mag,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  import adc_pkg::*;

  localparam int F  = LEVEL_FRAC_BITS;
  localparam int S  = SAMPLE_BITS;
  localparam int L  = F + 3;
  localparam int DW = S + F;
  localparam int PW = L + COEF_BITS;
  localparam int EW = (L > MIN_ENERGY_W) ? L : MIN_ENERGY_W;

  localparam logic [L-1:0]  ENV_ONE  = L'(1) << F;
  localparam logic [EW-1:0] ENV_CAP  = EW'({L{1'b1}});
  localparam logic [DW-1:0] NEG_MAG  = DW'(1) << (S - 1);
  localparam logic [DW-1:0] POS_MAX  = NEG_MAG - 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_LVL, S_DECAY, S_PSUB, S_EMUL, S_EUPD, S_OSTART, S_OUT, S_DELIV
  } state_t;

  state_t        state;
  logic          neg;
  logic [S-1:0]  mag;
  logic [L-1:0]  peak;
  logic [L-1:0]  env;
  logic [PW-1:0] prod;
  logic          rise;
  logic [S-1:0]  res;

  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_dividend;
  logic [L-1:0]  div_divisor;
  logic [DW-1:0] div_quot;

  logic [L-1:0]  tgt;
  logic [L-1:0]  level;
  logic [L-1:0]  peak_max;
  logic          at_or_above;
  logic [L-1:0]  env_diff;
  logic [L-1:0]  mul_a;
  logic [COEF_W-1:0] mul_b;
  logic [L-1:0]  step;
  logic [L-1:0]  env_move;
  logic [EW-1:0] floor_e;
  logic [EW-1:0] env_floored;
  logic [L-1:0]  env_next;
  logic [DW-1:0] q_sat;
  logic [DW-1:0] q_neg_val;
  logic [S-1:0]  res_next;
  logic          deliver;

  assign tgt = (cfg.target_level == '0) ? L'(1) : L'(cfg.target_level);

  assign div_start    = (state == S_IDLE && q_valid) || (state == S_OSTART);
  assign q_pop        = (state == S_IDLE) && q_valid;
  assign div_dividend = {((state == S_IDLE) ? q_mag : mag), {F{1'b0}}};
  assign div_divisor  = (state == S_IDLE) ? tgt : env;

  adc_div #(
    .DW (DW),
    .VW (L)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign level    = (div_quot[DW-1:L] != '0) ? {L{1'b1}} : div_quot[L-1:0];
  assign peak_max = (level > peak) ? level : peak;

  assign at_or_above = (peak >= env);
  assign env_diff    = at_or_above ? (peak - env) : (env - peak);
  assign mul_a       = (state == S_DECAY) ? peak : env_diff;
  assign mul_b       = (state == S_DECAY) ? cfg.peak_decay_coef :
                       (at_or_above ? cfg.attack_coef : cfg.release_coef);
  assign step        = prod[PW-1:COEF_BITS];

  // The move is never larger than the gap, so the envelope stays within the level range.
  assign env_move    = rise ? (env + step) : (env - step);
  assign floor_e     = (cfg.min_energy == '0) ? EW'(1) : EW'(cfg.min_energy);
  assign env_floored = (EW'(env_move) < floor_e) ? floor_e : EW'(env_move);
  assign env_next    = (env_floored > ENV_CAP) ? {L{1'b1}} : env_floored[L-1:0];

  assign q_sat     = neg ? ((div_quot > NEG_MAG) ? NEG_MAG : div_quot)
                         : ((div_quot > POS_MAX) ? POS_MAX : div_quot);
  assign q_neg_val = DW'(0) - q_sat;
  assign res_next  = neg ? q_neg_val[S-1:0] : q_sat[S-1:0];

  assign deliver = (state == S_DELIV) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      peak      <= '0;
      env       <= ENV_ONE;
      out_valid <= 1'b0;
    end else begin
      if (deliver) begin
        sample_out <= $signed(res);
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            neg   <= q_neg;
            mag   <= q_mag;
            state <= S_LVL;
          end
        end
        S_LVL: begin
          if (div_done) begin
            peak  <= peak_max;
            state <= S_DECAY;
          end
        end
        S_DECAY: begin
          prod  <= PW'(mul_a * mul_b);
          state <= S_PSUB;
        end
        S_PSUB: begin
          peak  <= peak - step;
          state <= S_EMUL;
        end
        S_EMUL: begin
          prod  <= PW'(mul_a * mul_b);
          rise  <= at_or_above;
          state <= S_EUPD;
        end
        S_EUPD: begin
          env   <= env_next;
          state <= S_OSTART;
        end
        S_OSTART: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (div_done) begin
            res   <= res_next;
            state <= S_DELIV;
          end
        end
        S_DELIV: begin
          if (deliver) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_env_nonzero: assert property (@(posedge clk) disable iff (rst) env != '0)
    else $error("gain envelope reached zero");

  a_pop_has_word: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_decay_no_growth: assert property (@(posedge clk) disable iff (rst)
    (state == S_PSUB) |=> (peak <= $past(peak)))
    else $error("peak grew during decay");

  a_out_from_deliver: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DELIV))
    else $error("output word loaded outside delivery");

endmodule

@@ rtl/audio_dynamics_compressor.sv @@
`timescale 1ns / 1ps

// Peak-envelope audio compressor: each accepted input word is one signed PCM sample and
// yields exactly one output word, the sample divided by a gain envelope that follows a
// decaying peak detector, truncated toward zero and saturated. Configuration is written
// through a plain register port; the user must write it only while the block is idle,
// which the block itself does not enforce. A two-word queue decouples the input from a
// sequencer that runs one sample at a time, using the shared one-bit-per-cycle divider
// once for the level and once for the output.
module audio_dynamics_compressor #(
  parameter int LEVEL_FRAC_BITS = adc_pkg::LEVEL_FRAC_BITS_DEF,
  parameter int SAMPLE_BITS     = adc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [adc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [adc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     sample_out
);

  import adc_pkg::*;

  adc_cfg_t               cfg;
  logic                   q_full;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_valid;
  logic                   push_neg;
  logic [SAMPLE_BITS-1:0] push_mag;
  logic [SAMPLE_BITS:0]   pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_level    <= TARGET_RESET;
      cfg.peak_decay_coef <= PEAK_DECAY_RESET;
      cfg.attack_coef     <= ATTACK_RESET;
      cfg.release_coef    <= RELEASE_RESET;
      cfg.min_energy      <= MIN_ENERGY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TARGET_LEVEL: cfg.target_level    <= cfg_data[TARGET_W-1:0];
        REG_PEAK_DECAY:   cfg.peak_decay_coef <= cfg_data[COEF_W-1:0];
        REG_ATTACK:       cfg.attack_coef     <= cfg_data[COEF_W-1:0];
        REG_RELEASE:      cfg.release_coef    <= cfg_data[COEF_W-1:0];
        REG_MIN_ENERGY:   cfg.min_energy      <= cfg_data[MIN_ENERGY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  adc_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_neg     (push_neg),
    .q_mag     (push_mag)
  );

  adc_fifo #(
    .WIDTH (SAMPLE_BITS + 1)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_neg, push_mag}),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .pop_data  (pop_data)
  );

  adc_back #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_neg      (pop_data[SAMPLE_BITS]),
    .q_mag      (pop_data[SAMPLE_BITS-1:0]),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
  );

endmodule
